// File: design/rgb_gain_and_saturation_boost_top_macros.svh
// Assertion macros for the RGB gain and saturation boost block.
// Used by the modules in this folder; expects clk and rst_n in scope.
`ifndef RGB_GAIN_AND_SATURATION_BOOST_TOP_MACROS_SVH
`define RGB_GAIN_AND_SATURATION_BOOST_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RGBSAT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RGBSAT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rgbsat_pkg.sv
// Shared types, widths and constants for the RGB gain and saturation boost block.
// No dependencies; used by rgbsat_divider and rgb_gain_and_saturation_boost_top.
package rgbsat_pkg;

    // Field and register widths
    localparam int IN_W      = 15;
    localparam int GAIN_W    = 12;
    localparam int SATF_W    = 13;
    localparam int ROOT_W    = 12;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int WGT_W     = 16;
    localparam int FRAC_W    = 10;

    // Datapath widths
    localparam int V_W     = IN_W + GAIN_W;        // gained channel, Q.10
    localparam int I_W     = WGT_W + V_W;          // old intensity, Q.26
    localparam int PM_W    = ROOT_W + V_W;         // mid stretch product
    localparam int PH_W    = SATF_W + V_W;         // max stretch product
    localparam int S_W     = 40;                   // stretched channel, Q.20
    localparam int N_W     = WGT_W + S_W;          // new intensity, Q.36
    localparam int I_LO_W  = 22;
    localparam int I_HI_W  = I_W - I_LO_W;
    localparam int PL_W    = S_W + I_LO_W;
    localparam int PHI_W   = S_W + I_HI_W;
    localparam int SUM_W   = 84;                   // s*I + N/2 scaled, Q.46
    localparam int Y_W     = SUM_W - FRAC_W;       // dividend
    localparam int Q_W     = 15;                   // quotient / output width
    localparam int REM_W   = N_W + Q_W;            // divider remainder
    localparam int DIV_STAGES   = Q_W + 1;         // saturation check + one bit each
    localparam int FRONT_STAGES = 7;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0] RED_GAIN_RST   = 12'd655;
    localparam logic [GAIN_W-1:0] GREEN_GAIN_RST = 12'd594;
    localparam logic [GAIN_W-1:0] BLUE_GAIN_RST  = 12'd1024;
    localparam logic [SATF_W-1:0] SAT_FACTOR_RST = 13'd1536;
    localparam logic [ROOT_W-1:0] SAT_ROOT_RST   = 12'd1254;

    // Unity stretch in Q.10
    localparam logic [SATF_W-1:0] SATF_UNITY = 13'd1024;
    localparam logic [ROOT_W-1:0] ROOT_UNITY = 12'd1024;

    // Intensity weights, Q0.16, indexed by channel
    localparam logic [WGT_W-1:0] W_RED   = 16'd31195;
    localparam logic [WGT_W-1:0] W_GREEN = 16'd19595;
    localparam logic [WGT_W-1:0] W_BLUE  = 16'd11469;
    localparam logic [2:0][WGT_W-1:0] WEIGHTS = {W_BLUE, W_GREEN, W_RED};

    localparam logic [Q_W-1:0] OUT_MAX = {Q_W{1'b1}};

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_GAIN   = 3'd0,
        REG_GREEN_GAIN = 3'd1,
        REG_BLUE_GAIN  = 3'd2,
        REG_SAT_FACTOR = 3'd3,
        REG_SAT_ROOT   = 3'd4
    } cfg_reg_t;

    // Channel codes
    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } ch_t;

    // Divider request: one dividend per channel and the shared divisor
    typedef struct packed {
        logic [2:0][Y_W-1:0] y;
        logic [N_W-1:0]      n;
    } div_req_t;

endpackage

// File: design/rgbsat_divider.sv
// Pipelined restoring divider: three dividends over one shared divisor, saturating.
// Depends on rgbsat_pkg and rgb_gain_and_saturation_boost_top_macros.svh.
`include "rgb_gain_and_saturation_boost_top_macros.svh"

module rgbsat_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rgbsat_pkg::div_req_t                 req,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [2:0][rgbsat_pkg::Q_W-1:0]      quo
);

    localparam int STAGES = rgbsat_pkg::DIV_STAGES;
    localparam int Q_W    = rgbsat_pkg::Q_W;
    localparam int N_W    = rgbsat_pkg::N_W;
    localparam int Y_W    = rgbsat_pkg::Y_W;
    localparam int REM_W  = rgbsat_pkg::REM_W;

    logic [STAGES-1:0]          vld_reg;
    logic [STAGES-1:0]          vld_next;
    logic [STAGES-1:0]          en;
    logic [N_W-1:0]             n_reg   [STAGES];
    logic [2:0][REM_W-1:0]      rem_reg [STAGES];
    logic [2:0][Q_W-1:0]        q_reg   [STAGES];
    logic [2:0]                 sat_reg [STAGES];

    // Stage enables: a stage moves when it is empty or the next one moves
    assign en[STAGES-1] = !vld_reg[STAGES-1] || !out_stall;
    for (genvar j = 0; j < STAGES - 1; j++) begin : g_en
        assign en[j] = !vld_reg[j] || en[j+1];
    end
    assign in_stall = !en[0];

    // Valid bits travel with the data
    assign vld_next = (en & {vld_reg[STAGES-2:0], in_valid}) | (~en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 0 checks saturation, stage j resolves quotient bit Q_W-j
    for (genvar j = 0; j < STAGES; j++) begin : g_stage
        logic [N_W-1:0]        n_next;
        logic [2:0][REM_W-1:0] rem_next;
        logic [2:0][Q_W-1:0]   q_next;
        logic [2:0]            sat_next;

        if (j == 0) begin : g_first
            always_comb
            begin
                n_next = req.n;
                for (int c = 0; c < 3; c++)
                begin
                    sat_next[c] = req.y[c] >= Y_W'({req.n, {Q_W{1'b0}}});
                    rem_next[c] = req.y[c][REM_W-1:0];
                    q_next[c]   = '0;
                end
            end
        end
        else begin : g_step
            localparam int BIT = Q_W - j;
            logic [REM_W-1:0] trial;
            logic [2:0]       ge;

            assign trial = REM_W'(n_reg[j-1]) << BIT;

            always_comb
            begin
                n_next = n_reg[j-1];
                for (int c = 0; c < 3; c++)
                begin
                    ge[c]         = rem_reg[j-1][c] >= trial;
                    sat_next[c]   = sat_reg[j-1][c];
                    rem_next[c]   = ge[c] ? rem_reg[j-1][c] - trial : rem_reg[j-1][c];
                    q_next[c]     = q_reg[j-1][c];
                    q_next[c][BIT] = ge[c];
                    // last bit: an overflowed quotient clips to full scale
                    if (BIT == 0 && sat_reg[j-1][c])
                    begin
                        q_next[c] = rgbsat_pkg::OUT_MAX;
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                n_reg[j]   <= n_next;
                rem_reg[j] <= rem_next;
                q_reg[j]   <= q_next;
                sat_reg[j] <= sat_next;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo       = q_reg[STAGES-1];

    // Checks
    `RGBSAT_ASSERT_IMP(a_div_stall_full, in_stall, &vld_reg, "divider stalled with a bubble")
    `RGBSAT_ASSERT_IMP(a_div_nonzero, vld_reg[0], n_reg[0] != '0, "divider saw a zero divisor")
    for (genvar j = 0; j < STAGES; j++) begin : g_chk
        logic [REM_W-1:0] bound;
        assign bound = REM_W'(n_reg[j]) << (Q_W - 1 - j + 1);
        for (genvar c = 0; c < 3; c++) begin : g_ch
            `RGBSAT_ASSERT_IMP(a_rem_bound, vld_reg[j], sat_reg[j][c] || (rem_reg[j][c] < bound), "remainder out of range")
        end
    end

endmodule

// File: design/rgb_gain_and_saturation_boost_top.sv
// Top level of the RGB white-balance gain and saturation boost block.
// Depends on rgbsat_pkg, rgbsat_divider and rgb_gain_and_saturation_boost_top_macros.svh.
//
// One RGB pixel per request, one result per request, in order. A pixel can be
// taken every cycle while in_stall is low. The pipe has 23 register stages:
// seven arithmetic stages (gain, channel order and weighting, stretch, stretched
// channels, weighting, intensity and partial products, dividend) followed by a
// sixteen-stage restoring divider that checks saturation in its first stage and
// resolves one quotient bit per stage after. Every stage holds while the one
// after it is full and stalled, and empty stages keep filling, so input requests
// are taken until all 23 stages hold a pixel. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no pixel is in
// flight, which the block itself does not enforce. Indexes above 4 are ignored.
// sat_factor of exactly 1.0 passes the gained channels through with rounding
// and clipping only.
`include "rgb_gain_and_saturation_boost_top_macros.svh"

module rgb_gain_and_saturation_boost_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [rgbsat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbsat_pkg::CFG_W-1:0]         cfg_data,
    // pixel in
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [rgbsat_pkg::IN_W-1:0]          red_in,
    input  logic [rgbsat_pkg::IN_W-1:0]          green_in,
    input  logic [rgbsat_pkg::IN_W-1:0]          blue_in,
    // pixel out
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [rgbsat_pkg::Q_W-1:0]           red_out,
    output logic [rgbsat_pkg::Q_W-1:0]           green_out,
    output logic [rgbsat_pkg::Q_W-1:0]           blue_out
);

    localparam int NS     = rgbsat_pkg::FRONT_STAGES;
    localparam int GAIN_W = rgbsat_pkg::GAIN_W;
    localparam int SATF_W = rgbsat_pkg::SATF_W;
    localparam int ROOT_W = rgbsat_pkg::ROOT_W;
    localparam int V_W    = rgbsat_pkg::V_W;
    localparam int I_W    = rgbsat_pkg::I_W;
    localparam int PM_W   = rgbsat_pkg::PM_W;
    localparam int PH_W   = rgbsat_pkg::PH_W;
    localparam int S_W    = rgbsat_pkg::S_W;
    localparam int N_W    = rgbsat_pkg::N_W;
    localparam int I_LO_W = rgbsat_pkg::I_LO_W;
    localparam int PL_W   = rgbsat_pkg::PL_W;
    localparam int PHI_W  = rgbsat_pkg::PHI_W;
    localparam int SUM_W  = rgbsat_pkg::SUM_W;
    localparam int FRAC_W = rgbsat_pkg::FRAC_W;
    localparam int Q_W    = rgbsat_pkg::Q_W;

    // Configuration registers
    logic [GAIN_W-1:0] red_gain_reg;
    logic [GAIN_W-1:0] green_gain_reg;
    logic [GAIN_W-1:0] blue_gain_reg;
    logic [SATF_W-1:0] sat_factor_reg;
    logic [ROOT_W-1:0] sat_root_reg;

    // Pipeline control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;
    logic          div_stall;

    // Stage 1: gained channels
    logic [2:0][V_W-1:0] v1_reg, v1_next;
    // Stage 2: ordered channels and weighted channels
    logic [V_W-1:0]      vlo2_reg, vlo2_next;
    logic [V_W-1:0]      dmd2_reg, dmd2_next;
    logic [V_W-1:0]      dhi2_reg, dhi2_next;
    rgbsat_pkg::ch_t     lo2_reg, lo2_next;
    rgbsat_pkg::ch_t     md2_reg, md2_next;
    rgbsat_pkg::ch_t     hi2_reg, hi2_next;
    logic [2:0][I_W-1:0] wv2_reg, wv2_next;
    // Stage 3: stretch products and old intensity
    logic                bypass;
    logic [ROOT_W-1:0]   root_eff;
    logic [SATF_W-1:0]   fact_eff;
    logic [PM_W-1:0]     pm3_reg, pm3_next;
    logic [PH_W-1:0]     ph3_reg, ph3_next;
    logic [V_W-1:0]      vlo3_reg;
    rgbsat_pkg::ch_t     lo3_reg, md3_reg, hi3_reg;
    logic [I_W-1:0]      i3_reg, i3_next;
    // Stage 4: stretched channels
    logic [S_W-1:0]      base4;
    logic [2:0][S_W-1:0] s4_reg, s4_next;
    logic [I_W-1:0]      i4_reg;
    // Stage 5: weighted stretched channels
    logic [2:0][N_W-1:0] ws5_reg, ws5_next;
    logic [2:0][S_W-1:0] s5_reg;
    logic [I_W-1:0]      i5_reg;
    // Stage 6: new intensity and partial products of s * I
    logic [N_W-1:0]        n6_reg, n6_next;
    logic [2:0][PL_W-1:0]  pl6_reg, pl6_next;
    logic [2:0][PHI_W-1:0] phi6_reg, phi6_next;
    // Stage 7: dividend and divisor
    logic [2:0][SUM_W-1:0] sum7;
    rgbsat_pkg::div_req_t  req7_reg, req7_next;

    logic [2:0][Q_W-1:0]   quo;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_gain_reg   <= rgbsat_pkg::RED_GAIN_RST;
            green_gain_reg <= rgbsat_pkg::GREEN_GAIN_RST;
            blue_gain_reg  <= rgbsat_pkg::BLUE_GAIN_RST;
            sat_factor_reg <= rgbsat_pkg::SAT_FACTOR_RST;
            sat_root_reg   <= rgbsat_pkg::SAT_ROOT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgbsat_pkg::REG_RED_GAIN:   red_gain_reg   <= cfg_data[GAIN_W-1:0];
                rgbsat_pkg::REG_GREEN_GAIN: green_gain_reg <= cfg_data[GAIN_W-1:0];
                rgbsat_pkg::REG_BLUE_GAIN:  blue_gain_reg  <= cfg_data[GAIN_W-1:0];
                rgbsat_pkg::REG_SAT_FACTOR: sat_factor_reg <= cfg_data[SATF_W-1:0];
                rgbsat_pkg::REG_SAT_ROOT:   sat_root_reg   <= cfg_data[ROOT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage enables, last one fed by the divider
    assign en[NS-1] = !vld_reg[NS-1] || !div_stall;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end
    assign in_stall = !en[0];

    assign vld_next = (en & {vld_reg[NS-2:0], in_valid}) | (~en & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage 1: white-balance gains
    always_comb
    begin
        v1_next[rgbsat_pkg::CH_RED]   = V_W'(red_in) * V_W'(red_gain_reg);
        v1_next[rgbsat_pkg::CH_GREEN] = V_W'(green_in) * V_W'(green_gain_reg);
        v1_next[rgbsat_pkg::CH_BLUE]  = V_W'(blue_in) * V_W'(blue_gain_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            v1_reg <= v1_next;
        end
    end

    // Stage 2: order channels into min/mid/max, weight each channel
    always_comb
    begin
        if (v1_reg[rgbsat_pkg::CH_RED] > v1_reg[rgbsat_pkg::CH_GREEN])
        begin
            if (v1_reg[rgbsat_pkg::CH_RED] > v1_reg[rgbsat_pkg::CH_BLUE])
            begin
                hi2_next = rgbsat_pkg::CH_RED;
                if (v1_reg[rgbsat_pkg::CH_GREEN] > v1_reg[rgbsat_pkg::CH_BLUE])
                begin
                    lo2_next = rgbsat_pkg::CH_BLUE;
                    md2_next = rgbsat_pkg::CH_GREEN;
                end
                else
                begin
                    lo2_next = rgbsat_pkg::CH_GREEN;
                    md2_next = rgbsat_pkg::CH_BLUE;
                end
            end
            else
            begin
                lo2_next = rgbsat_pkg::CH_GREEN;
                md2_next = rgbsat_pkg::CH_RED;
                hi2_next = rgbsat_pkg::CH_BLUE;
            end
        end
        else
        begin
            if (v1_reg[rgbsat_pkg::CH_GREEN] > v1_reg[rgbsat_pkg::CH_BLUE])
            begin
                hi2_next = rgbsat_pkg::CH_GREEN;
                if (v1_reg[rgbsat_pkg::CH_RED] > v1_reg[rgbsat_pkg::CH_BLUE])
                begin
                    lo2_next = rgbsat_pkg::CH_BLUE;
                    md2_next = rgbsat_pkg::CH_RED;
                end
                else
                begin
                    lo2_next = rgbsat_pkg::CH_RED;
                    md2_next = rgbsat_pkg::CH_BLUE;
                end
            end
            else
            begin
                lo2_next = rgbsat_pkg::CH_RED;
                md2_next = rgbsat_pkg::CH_GREEN;
                hi2_next = rgbsat_pkg::CH_BLUE;
            end
        end
        vlo2_next = v1_reg[lo2_next];
        dmd2_next = v1_reg[md2_next] - v1_reg[lo2_next];
        dhi2_next = v1_reg[hi2_next] - v1_reg[lo2_next];
        for (int c = 0; c < 3; c++)
        begin
            wv2_next[c] = I_W'(rgbsat_pkg::WEIGHTS[c]) * I_W'(v1_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            vlo2_reg <= vlo2_next;
            dmd2_reg <= dmd2_next;
            dhi2_reg <= dhi2_next;
            lo2_reg  <= lo2_next;
            md2_reg  <= md2_next;
            hi2_reg  <= hi2_next;
            wv2_reg  <= wv2_next;
        end
    end

    // Stage 3: stretch products; unity stretch in bypass keeps s = v * 1.0
    assign bypass   = (sat_factor_reg == rgbsat_pkg::SATF_UNITY);
    assign root_eff = bypass ? rgbsat_pkg::ROOT_UNITY : sat_root_reg;
    assign fact_eff = bypass ? rgbsat_pkg::SATF_UNITY : sat_factor_reg;

    always_comb
    begin
        pm3_next = PM_W'(root_eff) * PM_W'(dmd2_reg);
        ph3_next = PH_W'(fact_eff) * PH_W'(dhi2_reg);
        i3_next  = wv2_reg[0] + wv2_reg[1] + wv2_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pm3_reg  <= pm3_next;
            ph3_reg  <= ph3_next;
            vlo3_reg <= vlo2_reg;
            lo3_reg  <= lo2_reg;
            md3_reg  <= md2_reg;
            hi3_reg  <= hi2_reg;
            i3_reg   <= i3_next;
        end
    end

    // Stage 4: stretched channels back in red/green/blue order
    assign base4 = S_W'(vlo3_reg) << FRAC_W;

    always_comb
    begin
        s4_next          = '0;
        s4_next[lo3_reg] = base4;
        s4_next[md3_reg] = base4 + S_W'(pm3_reg);
        s4_next[hi3_reg] = base4 + S_W'(ph3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_reg <= s4_next;
            i4_reg <= i3_reg;
        end
    end

    // Stage 5: weight the stretched channels
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ws5_next[c] = N_W'(rgbsat_pkg::WEIGHTS[c]) * N_W'(s4_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ws5_reg <= ws5_next;
            s5_reg  <= s4_reg;
            i5_reg  <= i4_reg;
        end
    end

    // Stage 6: new intensity; s * I split into two partial products
    always_comb
    begin
        n6_next = ws5_reg[0] + ws5_reg[1] + ws5_reg[2];
        for (int c = 0; c < 3; c++)
        begin
            pl6_next[c]  = PL_W'(s5_reg[c]) * PL_W'(i5_reg[I_LO_W-1:0]);
            phi6_next[c] = PHI_W'(s5_reg[c]) * PHI_W'(i5_reg[I_W-1:I_LO_W]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            n6_reg   <= n6_next;
            pl6_reg  <= pl6_next;
            phi6_reg <= phi6_next;
        end
    end

    // Stage 7: dividend floor((s*I + N/2*1024) / 1024); zero intensity divides by one
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum7[c] = SUM_W'(pl6_reg[c]) + (SUM_W'(phi6_reg[c]) << I_LO_W)
                    + (SUM_W'(n6_reg) << (FRAC_W - 1));
            req7_next.y[c] = sum7[c][SUM_W-1:FRAC_W];
        end
        req7_next.n = (n6_reg == '0) ? N_W'(1) : n6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            req7_reg <= req7_next;
        end
    end

    // Divider and output register
    rgbsat_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NS-1]),
        .in_stall  (div_stall),
        .req       (req7_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .quo       (quo)
    );

    assign red_out   = quo[rgbsat_pkg::CH_RED];
    assign green_out = quo[rgbsat_pkg::CH_GREEN];
    assign blue_out  = quo[rgbsat_pkg::CH_BLUE];

    // Checks
    `RGBSAT_ASSERT_IMP(a_stall_full, in_stall, &vld_reg, "input stalled with a bubble in the pipe")
    `RGBSAT_ASSERT_IMP(a_order, vld_reg[1], dmd2_reg <= dhi2_reg, "mid channel above max channel")
    `RGBSAT_ASSERT_NXT(a_req_hold, vld_reg[NS-1] && div_stall, vld_reg[NS-1] && $stable(req7_reg), "divider request lost under stall")

endmodule

// File: tb/rgb_gain_and_saturation_boost_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_gain_and_saturation_boost_top: a directed table, then
// random pixels under random settings, checked against fixed_want or an internal predictor.
// Depends on rgbsat_pkg and the RTL of the block only.

module rgb_gain_and_saturation_boost_top_tb;

    localparam int IN_W      = rgbsat_pkg::IN_W;
    localparam int GAIN_W    = rgbsat_pkg::GAIN_W;
    localparam int SATF_W    = rgbsat_pkg::SATF_W;
    localparam int ROOT_W    = rgbsat_pkg::ROOT_W;
    localparam int CFG_W     = rgbsat_pkg::CFG_W;
    localparam int CFG_IDX_W = rgbsat_pkg::CFG_IDX_W;
    localparam int FRAC_W    = rgbsat_pkg::FRAC_W;
    localparam int Q_W       = rgbsat_pkg::Q_W;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_WAIT      = 11;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 54;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [IN_W-1:0] PIX_MAX = {IN_W{1'b1}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
    localparam logic [SATF_W-1:0] SATF_MAX = {SATF_W{1'b1}};
    localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};
    // indexes past the last register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [IN_W-1:0] r;
        logic [IN_W-1:0] g;
        logic [IN_W-1:0] b;
    } pixel_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_r;
        logic [GAIN_W-1:0] gain_g;
        logic [GAIN_W-1:0] gain_b;
        logic [SATF_W-1:0] sat;
        logic [ROOT_W-1:0] root;
    } settings_t;

    typedef struct packed {
        settings_t set;
        pixel_t    px;
        logic      fixed_want;
        pixel_t    want;
    } pixel_case_t;

    // register settings used by the directed table
    localparam settings_t SET_RESET = '{rgbsat_pkg::RED_GAIN_RST, rgbsat_pkg::GREEN_GAIN_RST,
                                        rgbsat_pkg::BLUE_GAIN_RST, rgbsat_pkg::SAT_FACTOR_RST,
                                        rgbsat_pkg::SAT_ROOT_RST};
    localparam settings_t SET_UNITY_BOOST = '{12'd1024, 12'd1024, 12'd1024,
                                              rgbsat_pkg::SAT_FACTOR_RST,
                                              rgbsat_pkg::SAT_ROOT_RST};
    localparam settings_t SET_BYPASS = '{12'd1024, 12'd1024, 12'd1024, rgbsat_pkg::SATF_UNITY,
                                         rgbsat_pkg::SAT_ROOT_RST};
    localparam settings_t SET_MAX_GAIN = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, rgbsat_pkg::SATF_UNITY,
                                           ROOT_MAX};
    localparam settings_t SET_ZERO_GAIN = '{12'd0, 12'd0, 12'd0, rgbsat_pkg::SAT_FACTOR_RST,
                                            rgbsat_pkg::SAT_ROOT_RST};
    localparam settings_t SET_NO_STRETCH = '{12'd1024, 12'd1024, 12'd1024, 13'd0, 12'd0};
    localparam settings_t SET_MAX_STRETCH = '{12'd1024, 12'd1024, 12'd1024, SATF_MAX, ROOT_MAX};

    // directed table; fixed_want rows carry an expectation that is plain by inspection
    localparam pixel_case_t DIRECTED_CASES [24] = '{
        // reset values: zero pixel has zero new intensity
        '{SET_RESET, '{15'd0, 15'd0, 15'd0}, 1'b1, '{15'd0, 15'd0, 15'd0}},
        '{SET_RESET, '{PIX_MAX, PIX_MAX, PIX_MAX}, 1'b0, '0},
        '{SET_RESET, '{PIX_MAX, 15'd0, 15'd0}, 1'b0, '0},
        '{SET_RESET, '{15'd0, 15'd0, PIX_MAX}, 1'b0, '0},
        // gray pixels keep their value under any boost
        '{SET_UNITY_BOOST, '{15'd5000, 15'd5000, 15'd5000}, 1'b1, '{15'd5000, 15'd5000, 15'd5000}},
        '{SET_UNITY_BOOST, '{PIX_MAX, PIX_MAX, PIX_MAX}, 1'b1, '{PIX_MAX, PIX_MAX, PIX_MAX}},
        // every channel order, then ties
        '{SET_UNITY_BOOST, '{15'd20000, 15'd10000, 15'd3000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd20000, 15'd3000, 15'd10000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd10000, 15'd3000, 15'd20000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd10000, 15'd20000, 15'd3000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd3000, 15'd20000, 15'd10000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd3000, 15'd10000, 15'd20000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd15000, 15'd15000, 15'd100}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd15000, 15'd100, 15'd100}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd15000, 15'd100, 15'd15000}, 1'b0, '0},
        '{SET_UNITY_BOOST, '{15'd0, PIX_MAX, PIX_MAX}, 1'b0, '0},
        // saturation of exactly one passes the gained channels through
        '{SET_BYPASS, '{PIX_MAX, 15'd0, 15'd12345}, 1'b1, '{PIX_MAX, 15'd0, 15'd12345}},
        '{SET_MAX_GAIN, '{PIX_MAX, PIX_MAX, PIX_MAX}, 1'b1, '{PIX_MAX, PIX_MAX, PIX_MAX}},
        '{SET_MAX_GAIN, '{15'd1, 15'd0, 15'd1}, 1'b1, '{15'd4, 15'd0, 15'd4}},
        // zero gains: nothing left to rescale
        '{SET_ZERO_GAIN, '{PIX_MAX, PIX_MAX, PIX_MAX}, 1'b1, '{15'd0, 15'd0, 15'd0}},
        // stretch below one collapses onto min; min of zero gives zero
        '{SET_NO_STRETCH, '{15'd1000, 15'd0, 15'd2000}, 1'b1, '{15'd0, 15'd0, 15'd0}},
        '{SET_NO_STRETCH, '{15'd1000, 15'd500, 15'd2000}, 1'b0, '0},
        // largest stretch drives the max channel into clipping
        '{SET_MAX_STRETCH, '{PIX_MAX, 15'd0, 15'd100}, 1'b0, '0},
        '{SET_MAX_STRETCH, '{15'd100, PIX_MAX, 15'd0}, 1'b0, '0}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [IN_W-1:0]  red_in;
    logic [IN_W-1:0]  green_in;
    logic [IN_W-1:0]  blue_in;
    logic             out_valid;
    logic             out_stall;
    logic [Q_W-1:0]   red_out;
    logic [Q_W-1:0]   green_out;
    logic [Q_W-1:0]   blue_out;

    settings_t cur_set;
    pixel_t    boosted_pending [$];
    pixel_t    head_px;
    bit        no_gaps;
    int        pixels_sent;
    int        results_checked;
    int        error_count;
    int        settings_applied;
    int        cycle_count;

    rgb_gain_and_saturation_boost_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Expected pixel after gain and saturation boost, exact in 128 bits
    function automatic pixel_t boost_pixel(pixel_t px);
        logic [127:0] gained [3];
        logic [127:0] stretched [3];
        logic [127:0] old_int;
        logic [127:0] new_int;
        logic [127:0] num;
        logic [127:0] quo;
        logic [Q_W-1:0] chan [3];
        rgbsat_pkg::ch_t lo;
        rgbsat_pkg::ch_t md;
        rgbsat_pkg::ch_t hi;
        pixel_t res;
        gained[rgbsat_pkg::CH_RED]   = 128'(px.r) * 128'(cur_set.gain_r);
        gained[rgbsat_pkg::CH_GREEN] = 128'(px.g) * 128'(cur_set.gain_g);
        gained[rgbsat_pkg::CH_BLUE]  = 128'(px.b) * 128'(cur_set.gain_b);
        if (cur_set.sat == rgbsat_pkg::SATF_UNITY)
        begin
            for (int k = 0; k < 3; k++)
            begin
                quo = (gained[k] + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
                chan[k] = (quo > rgbsat_pkg::OUT_MAX) ? rgbsat_pkg::OUT_MAX : quo[Q_W-1:0];
            end
        end
        else
        begin
            // min/mid/max with the same tie rules as the block
            if (gained[rgbsat_pkg::CH_RED] > gained[rgbsat_pkg::CH_GREEN])
            begin
                if (gained[rgbsat_pkg::CH_RED] > gained[rgbsat_pkg::CH_BLUE])
                begin
                    hi = rgbsat_pkg::CH_RED;
                    if (gained[rgbsat_pkg::CH_GREEN] > gained[rgbsat_pkg::CH_BLUE])
                    begin
                        lo = rgbsat_pkg::CH_BLUE;
                        md = rgbsat_pkg::CH_GREEN;
                    end
                    else
                    begin
                        lo = rgbsat_pkg::CH_GREEN;
                        md = rgbsat_pkg::CH_BLUE;
                    end
                end
                else
                begin
                    lo = rgbsat_pkg::CH_GREEN;
                    md = rgbsat_pkg::CH_RED;
                    hi = rgbsat_pkg::CH_BLUE;
                end
            end
            else
            begin
                if (gained[rgbsat_pkg::CH_GREEN] > gained[rgbsat_pkg::CH_BLUE])
                begin
                    hi = rgbsat_pkg::CH_GREEN;
                    if (gained[rgbsat_pkg::CH_RED] > gained[rgbsat_pkg::CH_BLUE])
                    begin
                        lo = rgbsat_pkg::CH_BLUE;
                        md = rgbsat_pkg::CH_RED;
                    end
                    else
                    begin
                        lo = rgbsat_pkg::CH_RED;
                        md = rgbsat_pkg::CH_BLUE;
                    end
                end
                else
                begin
                    lo = rgbsat_pkg::CH_RED;
                    md = rgbsat_pkg::CH_GREEN;
                    hi = rgbsat_pkg::CH_BLUE;
                end
            end
            stretched[lo] = gained[lo] << FRAC_W;
            stretched[md] = stretched[lo] + 128'(cur_set.root) * (gained[md] - gained[lo]);
            stretched[hi] = stretched[lo] + 128'(cur_set.sat) * (gained[hi] - gained[lo]);
            old_int = '0;
            new_int = '0;
            for (int k = 0; k < 3; k++)
            begin
                old_int += 128'(rgbsat_pkg::WEIGHTS[k]) * gained[k];
                new_int += 128'(rgbsat_pkg::WEIGHTS[k]) * stretched[k];
            end
            // s * I / (N * 1024), rounded half up, clipped
            for (int k = 0; k < 3; k++)
            begin
                if (new_int == '0)
                begin
                    chan[k] = '0;
                end
                else
                begin
                    num = ((stretched[k] * old_int) << 1) + (new_int << FRAC_W);
                    quo = num / (new_int << (FRAC_W + 1));
                    chan[k] = (quo > rgbsat_pkg::OUT_MAX) ? rgbsat_pkg::OUT_MAX
                                                          : quo[Q_W-1:0];
                end
            end
        end
        res.r = chan[rgbsat_pkg::CH_RED];
        res.g = chan[rgbsat_pkg::CH_GREEN];
        res.b = chan[rgbsat_pkg::CH_BLUE];
        return res;
    endfunction

    // Random pixel: mostly uniform, plus small, tied, extreme and near-gray pixels
    function automatic pixel_t random_pixel();
        pixel_t p;
        logic [IN_W-1:0] base;
        p.r = IN_W'($urandom_range(0, PIX_MAX));
        p.g = IN_W'($urandom_range(0, PIX_MAX));
        p.b = IN_W'($urandom_range(0, PIX_MAX));
        base = IN_W'($urandom_range(0, PIX_MAX - 255));
        case ($urandom_range(0, 7))
            4:
            begin
                p.r = IN_W'($urandom_range(0, 255));
                p.g = IN_W'($urandom_range(0, 255));
                p.b = IN_W'($urandom_range(0, 255));
            end
            5:
            begin
                case ($urandom_range(0, 2))
                    0: p.g = p.r;
                    1: p.b = p.g;
                    default: p.b = p.r;
                endcase
            end
            6:
            begin
                p.r = $urandom_range(0, 1) ? PIX_MAX : '0;
                p.g = $urandom_range(0, 1) ? PIX_MAX : '0;
                p.b = $urandom_range(0, 2) == 0 ? p.b : ($urandom_range(0, 1) ? PIX_MAX : '0);
            end
            7:
            begin
                p.r = base + IN_W'($urandom_range(0, 255));
                p.g = base + IN_W'($urandom_range(0, 255));
                p.b = base + IN_W'($urandom_range(0, 255));
            end
            default: ;
        endcase
        return p;
    endfunction

    // Random register value with bias toward zero, full scale and unity
    function automatic logic [CFG_W-1:0] pick_setting(int unsigned top);
        logic [CFG_W-1:0] val;
        case ($urandom_range(0, 5))
            0: val = '0;
            1: val = CFG_W'(top);
            2: val = CFG_W'(rgbsat_pkg::SATF_UNITY);
            3, 4: val = CFG_W'($urandom_range(512, 2047));
            default: val = CFG_W'($urandom_range(0, top));
        endcase
        return val;
    endfunction

    // One register write; the local copy is masked to the register width
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            rgbsat_pkg::REG_RED_GAIN:   cur_set.gain_r = data[GAIN_W-1:0];
            rgbsat_pkg::REG_GREEN_GAIN: cur_set.gain_g = data[GAIN_W-1:0];
            rgbsat_pkg::REG_BLUE_GAIN:  cur_set.gain_b = data[GAIN_W-1:0];
            rgbsat_pkg::REG_SAT_FACTOR: cur_set.sat    = data[SATF_W-1:0];
            rgbsat_pkg::REG_SAT_ROOT:   cur_set.root   = data[ROOT_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set, with junk in the unused top bit of the 12-bit registers
    // and a stray write to an index past the register file
    task automatic apply_settings(input settings_t s);
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), CFG_W'($urandom));
        write_reg(rgbsat_pkg::REG_RED_GAIN, {1'($urandom), s.gain_r});
        write_reg(rgbsat_pkg::REG_GREEN_GAIN, {1'($urandom), s.gain_g});
        write_reg(rgbsat_pkg::REG_BLUE_GAIN, {1'($urandom), s.gain_b});
        write_reg(rgbsat_pkg::REG_SAT_FACTOR, s.sat);
        write_reg(rgbsat_pkg::REG_SAT_ROOT, {1'($urandom), s.root});
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // Present one pixel request after a random gap and wait until it is taken
    task automatic send_pixel(input pixel_t px, input logic fixed_want, input pixel_t want);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= px.r;
        green_in <= px.g;
        blue_in  <= px.b;
        do @(posedge clk); while (in_stall);
        boosted_pending.push_back(fixed_want ? want : boost_pixel(px));
        pixels_sent++;
    endtask

    // Stop sending and let every pixel in flight come out
    task automatic drain_pixels();
        @(negedge clk);
        in_valid <= 1'b0;
        while (boosted_pending.size() != 0) @(posedge clk);
    endtask

    // Output side: random stall before each result
    initial
    begin : result_sink
        int unsigned hold;
        @(posedge rst_n);
        forever
        begin
            hold = no_gaps ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (boosted_pending.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                         red_out, green_out, blue_out);
            end
            else
            begin
                head_px = boosted_pending.pop_front();
                results_checked++;
                if (red_out !== head_px.r)
                begin
                    error_count++;
                    $display("%0t: red_out expected %0d actual %0d", $time, head_px.r, red_out);
                end
                if (green_out !== head_px.g)
                begin
                    error_count++;
                    $display("%0t: green_out expected %0d actual %0d", $time, head_px.g,
                             green_out);
                end
                if (blue_out !== head_px.b)
                begin
                    error_count++;
                    $display("%0t: blue_out expected %0d actual %0d", $time, head_px.b, blue_out);
                end
            end
        end
    end

    // Run-length guard
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time, CYCLE_LIMIT,
                 boosted_pending.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : main_flow
        settings_t rnd_set;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = rgbsat_pkg::REG_RED_GAIN;
        cfg_data  = '0;
        in_valid  = 1'b0;
        red_in    = '0;
        green_in  = '0;
        blue_in   = '0;
        out_stall = 1'b0;
        no_gaps   = 1'b0;
        pixels_sent      = 0;
        results_checked  = 0;
        error_count      = 0;
        settings_applied = 0;
        cur_set = SET_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table; settings change only once the pipeline is empty
        foreach (DIRECTED_CASES[i])
        begin
            if (DIRECTED_CASES[i].set != cur_set)
            begin
                drain_pixels();
                apply_settings(DIRECTED_CASES[i].set);
            end
            send_pixel(DIRECTED_CASES[i].px, DIRECTED_CASES[i].fixed_want,
                       DIRECTED_CASES[i].want);
        end

        // random phases, each under its own register settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pixels();
            rnd_set.gain_r = GAIN_W'(pick_setting(GAIN_MAX));
            rnd_set.gain_g = GAIN_W'(pick_setting(GAIN_MAX));
            rnd_set.gain_b = GAIN_W'(pick_setting(GAIN_MAX));
            rnd_set.sat    = ($urandom_range(0, 3) == 0) ? rgbsat_pkg::SATF_UNITY
                                                         : pick_setting(SATF_MAX);
            rnd_set.root   = ROOT_W'(pick_setting(ROOT_MAX));
            apply_settings(rnd_set);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                // occasional stretches with no idling on either side
                if ($urandom_range(0, 23) == 0)
                    no_gaps = !no_gaps;
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end

        drain_pixels();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d pixels (%0d directed) under %0d register settings.", pixels_sent,
                 $size(DIRECTED_CASES), settings_applied + 1);
        $display("Compared %0d results in %0d cycles, %0d mismatches.", results_checked,
                 cycle_count, error_count);
        if (error_count == 0 && boosted_pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
